/* hw/rtl/tse_pkg.sv */
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the TLS server-name extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int OffW   = 17;
    localparam int SumW   = 18;
    localparam int LenW   = 16;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_NO_SNI     = 2'd2;
    localparam logic [1:0] ST_INVALID    = 2'd3;

    localparam logic       KIND_NAME   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_req;

    typedef struct packed {
        logic            result_kind;
        logic [7:0]      name_byte;
        logic [1:0]      parse_status;
        logic [LenW-1:0] name_length;
        logic            final_result;
    } t_out_req;

    // Results caused by one payload byte: an optional name byte, then an
    // optional final status.
    typedef struct packed {
        logic            has_name;
        logic [7:0]      name_byte;
        logic            has_status;
        logic [1:0]      status;
        logic [LenW-1:0] length;
    } t_pair;

endpackage

/* hw/rtl/tse_parser.sv */
// ----------------------------------------------------------------------------
// tse_parser
// Input register and ClientHello parse state; one byte per cycle unless the result queue stalls.
// ----------------------------------------------------------------------------
module tse_parser import tse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    output logic    o_pair_valid,
    output t_pair   o_pair,
    input  logic    i_pair_ready
);

    localparam logic [4:0] PH_HDR      = 5'd0;
    localparam logic [4:0] PH_HDR_FAIL = 5'd1;
    localparam logic [4:0] PH_HTYPE    = 5'd2;
    localparam logic [4:0] PH_SID      = 5'd3;
    localparam logic [4:0] PH_CS_HI    = 5'd4;
    localparam logic [4:0] PH_CS_LO    = 5'd5;
    localparam logic [4:0] PH_CM       = 5'd6;
    localparam logic [4:0] PH_EXT_HI   = 5'd7;
    localparam logic [4:0] PH_EXT_LO   = 5'd8;
    localparam logic [4:0] PH_XT0      = 5'd9;
    localparam logic [4:0] PH_XT1      = 5'd10;
    localparam logic [4:0] PH_XL0      = 5'd11;
    localparam logic [4:0] PH_XL1      = 5'd12;
    localparam logic [4:0] PH_NT       = 5'd13;
    localparam logic [4:0] PH_NL0      = 5'd14;
    localparam logic [4:0] PH_NL1      = 5'd15;
    localparam logic [4:0] PH_NAME     = 5'd16;
    localparam logic [4:0] PH_DONE     = 5'd17;

    localparam logic [OffW-1:0] HDR_LEN    = OffW'(5);
    localparam logic [SumW-1:0] HELLO_SID  = SumW'(5 + 38);
    localparam logic [OffW-1:0] OFFSET_MAX = {OffW{1'b1}};
    localparam logic [7:0]      CT_HANDSHAKE = 8'h16;
    localparam logic [7:0]      HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0]      V2_HELLO = 8'h01;

    logic            r_in_valid;
    t_in_req         r_in;
    logic            adv;

    logic [4:0]      r_phase,    n_phase;
    logic [OffW-1:0] r_offset,   n_offset;
    logic [OffW-1:0] r_rec_end,  n_rec_end;
    logic [OffW-1:0] r_ext_end,  n_ext_end;
    logic [OffW-1:0] r_sn_end,   n_sn_end;
    logic [SumW-1:0] r_nfo,      n_nfo;
    logic [7:0]      r_acc,      n_acc;
    logic [7:0]      r_first,    n_first;
    logic [LenW-1:0] r_left,     n_left;
    logic [LenW-1:0] r_found,    n_found;
    logic [1:0]      r_lat,      n_lat;

    logic [7:0]      b;
    logic [SumW-1:0] idx_w;
    logic [LenW-1:0] len;
    logic [SumW-1:0] sum_len;
    logic [OffW-1:0] rec_calc;
    logic            ext_go;
    logic [SumW-1:0] ext_q;
    logic            ent_go;
    logic [SumW-1:0] ent_r;
    logic            nm_valid;
    logic            st_valid;
    logic [1:0]      st_code;

    assign adv     = r_in_valid && i_pair_ready;
    assign o_ready = !r_in_valid || i_pair_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in <= i_req;
        end
    end

    assign b        = r_in.data_byte;
    assign idx_w    = {1'b0, r_offset};
    assign len      = {r_acc, b};
    assign sum_len  = idx_w + SumW'(1) + {2'b00, len};
    assign rec_calc = {1'b0, len} + HDR_LEN;

    always_comb begin
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_rec_end = r_rec_end;
        n_ext_end = r_ext_end;
        n_sn_end  = r_sn_end;
        n_nfo     = r_nfo;
        n_acc     = r_acc;
        n_first   = r_first;
        n_left    = r_left;
        n_found   = r_found;
        n_lat     = r_lat;
        ext_go    = 1'b0;
        ext_q     = '0;
        ent_go    = 1'b0;
        ent_r     = '0;
        nm_valid  = 1'b0;
        st_valid  = 1'b0;
        st_code   = ST_FOUND;

        if (adv) begin
            if (r_phase == PH_HDR) begin
                if (r_offset < HDR_LEN) begin
                    case (r_offset[2:0])
                        3'd0: n_first = b;
                        3'd1: n_acc = b;
                        3'd2: begin
                            if (r_first[7] && b == V2_HELLO) begin
                                n_lat   = ST_NO_SNI;
                                n_phase = PH_HDR_FAIL;
                            end else if (r_first != CT_HANDSHAKE) begin
                                n_lat   = ST_INVALID;
                                n_phase = PH_HDR_FAIL;
                            end else if (r_acc < 8'd3) begin
                                n_lat   = ST_NO_SNI;
                                n_phase = PH_HDR_FAIL;
                            end
                        end
                        3'd3: n_acc = b;
                        default: begin
                            n_rec_end = rec_calc;
                            if (rec_calc == HDR_LEN) begin
                                n_lat   = ST_INVALID;
                                n_phase = PH_DONE;
                            end else begin
                                n_nfo   = {1'b0, HDR_LEN};
                                n_phase = PH_HTYPE;
                            end
                        end
                    endcase
                end
            end else if (r_phase != PH_HDR_FAIL && r_phase != PH_DONE &&
                         r_offset < r_rec_end && idx_w == r_nfo) begin
                case (r_phase)
                    PH_HTYPE: begin
                        if (b != HS_CLIENT_HELLO) begin
                            n_lat   = ST_INVALID;
                            n_phase = PH_DONE;
                        end else begin
                            n_nfo   = HELLO_SID;
                            n_phase = PH_SID;
                        end
                    end
                    PH_SID: begin
                        n_nfo   = idx_w + SumW'(1) + {10'd0, b};
                        n_phase = PH_CS_HI;
                    end
                    PH_CS_HI: begin
                        n_acc   = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_CS_LO;
                    end
                    PH_CS_LO: begin
                        n_nfo   = sum_len;
                        n_phase = PH_CM;
                    end
                    PH_CM: begin
                        n_nfo   = idx_w + SumW'(1) + {10'd0, b};
                        n_phase = PH_EXT_HI;
                    end
                    PH_EXT_HI: begin
                        n_acc   = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_EXT_LO;
                    end
                    PH_EXT_LO: begin
                        if (sum_len > {1'b0, r_rec_end}) begin
                            n_lat   = ST_INCOMPLETE;
                            n_phase = PH_DONE;
                        end else begin
                            n_ext_end = sum_len[OffW-1:0];
                            ext_go    = 1'b1;
                            ext_q     = idx_w + SumW'(1);
                        end
                    end
                    PH_XT0: begin
                        n_first = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_XT1;
                    end
                    PH_XT1: begin
                        n_first = ((r_first | b) != 8'd0) ? 8'd1 : 8'd0;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_XL0;
                    end
                    PH_XL0: begin
                        n_acc   = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_XL1;
                    end
                    PH_XL1: begin
                        if (r_first == 8'd0) begin
                            if (sum_len > {1'b0, r_ext_end}) begin
                                n_lat   = ST_INVALID;
                                n_phase = PH_DONE;
                            end else begin
                                n_sn_end = sum_len[OffW-1:0];
                                ent_go   = 1'b1;
                                ent_r    = idx_w + SumW'(3);
                            end
                        end else begin
                            ext_go = 1'b1;
                            ext_q  = sum_len;
                        end
                    end
                    PH_NT: begin
                        n_first = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_NL0;
                    end
                    PH_NL0: begin
                        n_acc   = b;
                        n_nfo   = idx_w + SumW'(1);
                        n_phase = PH_NL1;
                    end
                    PH_NL1: begin
                        if (sum_len > {1'b0, r_sn_end}) begin
                            n_lat   = ST_INVALID;
                            n_phase = PH_DONE;
                        end else if (r_first == 8'd0) begin
                            n_found = len;
                            n_lat   = ST_FOUND;
                            if (len == '0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_left  = len;
                                n_nfo   = idx_w + SumW'(1);
                                n_phase = PH_NAME;
                            end
                        end else begin
                            ent_go = 1'b1;
                            ent_r  = sum_len;
                        end
                    end
                    PH_NAME: begin
                        nm_valid = 1'b1;
                        n_left   = r_left - LenW'(1);
                        n_nfo    = idx_w + SumW'(1);
                        if (r_left == LenW'(1)) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (ext_go) begin
                if (ext_q == {1'b0, n_ext_end}) begin
                    n_lat   = ST_NO_SNI;
                    n_phase = PH_DONE;
                end else if (ext_q + SumW'(4) > {1'b0, n_ext_end}) begin
                    n_lat   = ST_INVALID;
                    n_phase = PH_DONE;
                end else begin
                    n_nfo   = ext_q;
                    n_phase = PH_XT0;
                end
            end

            if (ent_go) begin
                if (ent_r + SumW'(3) < {1'b0, n_sn_end}) begin
                    n_nfo   = ent_r;
                    n_phase = PH_NT;
                end else if (ent_r == {1'b0, n_sn_end}) begin
                    n_lat   = ST_NO_SNI;
                    n_phase = PH_DONE;
                end else begin
                    n_lat   = ST_INVALID;
                    n_phase = PH_DONE;
                end
            end

            n_offset = (r_offset < OFFSET_MAX) ? r_offset + OffW'(1) : r_offset;

            if (r_in.end_of_data) begin
                st_valid = 1'b1;
                if (n_offset < HDR_LEN) begin
                    st_code = ST_INCOMPLETE;
                end else if (n_phase == PH_HDR_FAIL) begin
                    st_code = n_lat;
                end else if (n_offset < n_rec_end) begin
                    st_code = ST_INCOMPLETE;
                end else if (n_phase == PH_DONE || n_phase == PH_NAME) begin
                    st_code = n_lat;
                end else if (n_phase == PH_EXT_HI && n_nfo == {1'b0, n_rec_end}) begin
                    st_code = ST_NO_SNI;
                end else begin
                    st_code = ST_INVALID;
                end
                n_phase   = PH_HDR;
                n_offset  = '0;
                n_rec_end = '0;
                n_ext_end = '0;
                n_sn_end  = '0;
                n_nfo     = '0;
                n_acc     = '0;
                n_first   = '0;
                n_left    = '0;
                n_found   = '0;
                n_lat     = ST_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_offset  <= '0;
            r_rec_end <= '0;
            r_ext_end <= '0;
            r_sn_end  <= '0;
            r_nfo     <= '0;
            r_acc     <= '0;
            r_first   <= '0;
            r_left    <= '0;
            r_found   <= '0;
            r_lat     <= ST_FOUND;
        end else begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_rec_end <= n_rec_end;
            r_ext_end <= n_ext_end;
            r_sn_end  <= n_sn_end;
            r_nfo     <= n_nfo;
            r_acc     <= n_acc;
            r_first   <= n_first;
            r_left    <= n_left;
            r_found   <= n_found;
            r_lat     <= n_lat;
        end
    end

    assign o_pair_valid      = adv && (nm_valid || st_valid);
    assign o_pair.has_name   = nm_valid;
    assign o_pair.name_byte  = b;
    assign o_pair.has_status = st_valid;
    assign o_pair.status     = st_code;
    assign o_pair.length     = (st_code == ST_FOUND) ? r_found : '0;

endmodule

/* hw/rtl/tse_out_queue.sv */
// ----------------------------------------------------------------------------
// tse_out_queue
// Two-entry result queue; splits a name byte and a final status into
// separate output requests.
// ----------------------------------------------------------------------------
module tse_out_queue import tse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pair_valid,
    input  t_pair    i_pair,
    output logic     o_pair_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);

    t_pair      r_entry [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_name_sent;

    t_pair      head;
    logic       show_name;
    logic       push;
    logic       pop;
    logic       take;

    assign head         = r_entry[r_rd_ptr];
    assign show_name    = head.has_name && !r_name_sent;
    assign o_valid      = (r_count != 2'd0);
    assign o_pair_ready = (r_count != 2'd2);
    assign push         = i_pair_valid && o_pair_ready;
    assign take         = o_valid && i_ready;
    assign pop          = take && !(show_name && head.has_status);

    always_comb begin
        if (show_name) begin
            o_req.result_kind  = KIND_NAME;
            o_req.name_byte    = head.name_byte;
            o_req.parse_status = ST_FOUND;
            o_req.name_length  = '0;
            o_req.final_result = 1'b0;
        end else begin
            o_req.result_kind  = KIND_STATUS;
            o_req.name_byte    = '0;
            o_req.parse_status = head.status;
            o_req.name_length  = head.length;
            o_req.final_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_count     <= 2'd0;
            r_name_sent <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr    <= !r_rd_ptr;
                r_name_sent <= 1'b0;
            end else if (take) begin
                r_name_sent <= 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/tls_sni_hostname_extractor.sv */
// ----------------------------------------------------------------------------
// tls_sni_hostname_extractor
// Streams the first SNI host name out of a TLS ClientHello, byte by byte.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle. Each byte passes an input register and
// the parse logic, then lands in a two-entry result queue, from which its
// results are presented in order. A byte yields at most a host name byte
// and, on end_of_data, a final status; a byte that yields both is sent as
// two separate output requests, name first, and the input keeps flowing as
// long as the result queue has a free entry.
module tls_sni_hostname_extractor import tse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);

    logic  pair_valid;
    logic  pair_ready;
    t_pair pair;

    tse_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req        (i_req),
        .o_pair_valid (pair_valid),
        .o_pair       (pair),
        .i_pair_ready (pair_ready)
    );

    tse_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .i_pair       (pair),
        .o_pair_ready (pair_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_req        (o_req)
    );

endmodule

/* hw/rtl/tse_checker.sv */
// ----------------------------------------------------------------------------
// tse_checker
// Port-level checks for the SNI extractor, bound to the top level.
// ----------------------------------------------------------------------------
module tse_checker import tse_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_ready,
    input t_out_req o_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_req))
        else $error("output request changed while stalled");

    a_name_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req.result_kind == KIND_NAME |->
            !o_req.final_result && o_req.parse_status == ST_FOUND &&
            o_req.name_length == '0)
        else $error("name byte carries status fields");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req.result_kind == KIND_STATUS |->
            o_req.final_result && o_req.name_byte == 8'd0)
        else $error("status request malformed");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req.result_kind == KIND_STATUS &&
            o_req.parse_status != ST_FOUND |-> o_req.name_length == '0)
        else $error("length reported without a found name");

endmodule

bind tls_sni_hostname_extractor tse_checker u_tse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_req   (o_req)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tls_sni_hostname_extractor. ClientHello payloads,
// clean, truncated, corrupted or plain noise, are sent one byte per request.
// A local parser predicts each streamed host name byte and each final status.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tse_pkg::*;

    localparam int unsigned HDR_BYTES       = 5;
    localparam int unsigned SESSION_ID_AT   = HDR_BYTES + 38;
    localparam int unsigned OFFSET_SAT      = 32'h1FFFF;
    localparam int unsigned BYTES_PER_PHASE = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;

    localparam logic [7:0]  CT_HANDSHAKE    = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0]  SSL2_HELLO      = 8'h01;
    localparam logic [7:0]  TLS_MAJOR       = 8'h03;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_HOST       = 8'h00;

    typedef enum logic [4:0] {
        PH_RECORD_HDR, PH_HDR_VERDICT, PH_HS_TYPE, PH_SESSION_ID,
        PH_SUITES_HI, PH_SUITES_LO, PH_COMPRESSION, PH_EXTLEN_HI,
        PH_EXTLEN_LO, PH_EXT_TYPE0, PH_EXT_TYPE1, PH_EXT_LEN0,
        PH_EXT_LEN1, PH_NAME_TYPE, PH_NAME_LEN0, PH_NAME_LEN1,
        PH_NAME_BYTES, PH_CONCLUDED
    } t_hello_phase;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_in_req  i_req   = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_out_req o_req;

    tls_sni_hostname_extractor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_req)
    );

    t_in_req     payload_bytes[$];
    t_out_req    sni_results_due[$];
    logic [7:0]  hello[$];
    int unsigned field_at[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned bytes_queued  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned name_bytes_seen = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    t_out_req    due;

    // parser state
    t_hello_phase phase = PH_RECORD_HDR;
    int unsigned  pos, rec_end, ext_end, list_end, next_off;
    logic [7:0]   hdr_type, hi_byte, ext_type_hi, entry_type;
    logic         ext_other;
    logic [15:0]  names_left, name_len;
    logic [1:0]   verdict;

    task automatic parser_clear();
        phase = PH_RECORD_HDR;
        pos = 0; rec_end = 0; ext_end = 0; list_end = 0; next_off = 0;
        hdr_type = '0; hi_byte = '0; ext_type_hi = '0; entry_type = '0;
        ext_other = 1'b0; names_left = '0; name_len = '0; verdict = ST_FOUND;
    endtask

    task automatic settle(logic [1:0] code);
        verdict = code;
        phase   = PH_CONCLUDED;
    endtask

    task automatic at_extension(int unsigned q);
        if (q == ext_end) settle(ST_NO_SNI);
        else if (q + 4 > ext_end) settle(ST_INVALID);
        else begin
            next_off = q;
            phase    = PH_EXT_TYPE0;
        end
    endtask

    task automatic at_name_entry(int unsigned r);
        if (r + 3 < list_end) begin
            next_off = r;
            phase    = PH_NAME_TYPE;
        end else if (r == list_end) settle(ST_NO_SNI);
        else settle(ST_INVALID);
    endtask

    task automatic post_result(logic kind, logic [7:0] nb, logic [1:0] st, logic [15:0] len);
        t_out_req r;
        r.result_kind  = kind;
        r.name_byte    = nb;
        r.parse_status = st;
        r.name_length  = len;
        r.final_result = (kind == KIND_STATUS);
        sni_results_due.push_back(r);
    endtask

    function automatic logic [1:0] status_at_close(int unsigned n);
        if (n < HDR_BYTES) return ST_INCOMPLETE;
        if (phase == PH_HDR_VERDICT) return verdict;
        if (n < rec_end) return ST_INCOMPLETE;
        if (phase == PH_CONCLUDED || phase == PH_NAME_BYTES) return verdict;
        if (phase == PH_EXTLEN_HI && next_off == rec_end) return ST_NO_SNI;
        return ST_INVALID;
    endfunction

    task automatic hello_parse_byte(t_in_req rq);
        int unsigned idx, len;
        logic [7:0]  b;
        logic [1:0]  st;
        idx = pos;
        b   = rq.data_byte;
        if (phase == PH_RECORD_HDR) begin
            case (idx)
                0: hdr_type = b;
                1, 3: hi_byte = b;
                2: begin
                    if (hdr_type[7] && b == SSL2_HELLO) begin
                        verdict = ST_NO_SNI;
                        phase   = PH_HDR_VERDICT;
                    end else if (hdr_type != CT_HANDSHAKE) begin
                        verdict = ST_INVALID;
                        phase   = PH_HDR_VERDICT;
                    end else if (hi_byte < TLS_MAJOR) begin
                        verdict = ST_NO_SNI;
                        phase   = PH_HDR_VERDICT;
                    end
                end
                4: begin
                    rec_end = {hi_byte, b} + HDR_BYTES;
                    if (rec_end == HDR_BYTES) settle(ST_INVALID);
                    else begin
                        next_off = HDR_BYTES;
                        phase    = PH_HS_TYPE;
                    end
                end
                default: ;
            endcase
        end else if (phase != PH_HDR_VERDICT && phase != PH_CONCLUDED &&
                     idx < rec_end && idx == next_off) begin
            next_off = idx + 1;
            case (phase)
                PH_HS_TYPE: begin
                    if (b != HS_CLIENT_HELLO) settle(ST_INVALID);
                    else begin
                        next_off = SESSION_ID_AT;
                        phase    = PH_SESSION_ID;
                    end
                end
                PH_SESSION_ID: begin
                    next_off = idx + 1 + b;
                    phase    = PH_SUITES_HI;
                end
                PH_SUITES_HI: begin
                    hi_byte = b;
                    phase   = PH_SUITES_LO;
                end
                PH_SUITES_LO: begin
                    next_off = idx + 1 + {hi_byte, b};
                    phase    = PH_COMPRESSION;
                end
                PH_COMPRESSION: begin
                    next_off = idx + 1 + b;
                    phase    = PH_EXTLEN_HI;
                end
                PH_EXTLEN_HI: begin
                    hi_byte = b;
                    phase   = PH_EXTLEN_LO;
                end
                PH_EXTLEN_LO: begin
                    len = {hi_byte, b};
                    if (idx + 1 + len > rec_end) settle(ST_INCOMPLETE);
                    else begin
                        ext_end = idx + 1 + len;
                        at_extension(idx + 1);
                    end
                end
                PH_EXT_TYPE0: begin
                    ext_type_hi = b;
                    phase       = PH_EXT_TYPE1;
                end
                PH_EXT_TYPE1: begin
                    ext_other = ({ext_type_hi, b} != EXT_SERVER_NAME);
                    phase     = PH_EXT_LEN0;
                end
                PH_EXT_LEN0: begin
                    hi_byte = b;
                    phase   = PH_EXT_LEN1;
                end
                PH_EXT_LEN1: begin
                    len = {hi_byte, b};
                    if (ext_other) at_extension(idx + 1 + len);
                    else if (idx + 1 + len > ext_end) settle(ST_INVALID);
                    else begin
                        // list length is skipped unchecked
                        list_end = idx + 1 + len;
                        at_name_entry(idx + 3);
                    end
                end
                PH_NAME_TYPE: begin
                    entry_type = b;
                    phase      = PH_NAME_LEN0;
                end
                PH_NAME_LEN0: begin
                    hi_byte = b;
                    phase   = PH_NAME_LEN1;
                end
                PH_NAME_LEN1: begin
                    len = {hi_byte, b};
                    if (idx + 1 + len > list_end) settle(ST_INVALID);
                    else if (entry_type == NAME_HOST) begin
                        name_len = 16'(len);
                        verdict  = ST_FOUND;
                        if (len == 0) phase = PH_CONCLUDED;
                        else begin
                            names_left = 16'(len);
                            phase      = PH_NAME_BYTES;
                        end
                    end else at_name_entry(idx + 1 + len);
                end
                PH_NAME_BYTES: begin
                    post_result(KIND_NAME, b, ST_FOUND, '0);
                    names_left = names_left - 16'd1;
                    if (names_left == 0) phase = PH_CONCLUDED;
                end
                default: ;
            endcase
        end
        pos = (idx < OFFSET_SAT) ? idx + 1 : OFFSET_SAT;
        if (rq.end_of_data) begin
            st = status_at_close(pos);
            post_result(KIND_STATUS, '0, st, (st == ST_FOUND) ? name_len : 16'd0);
            parser_clear();
        end
    endtask

    // ---------------- stimulus construction ----------------

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    task automatic put(logic [7:0] b, bit is_field);
        if (is_field) field_at.push_back(hello.size());
        hello.push_back(b);
    endtask

    task automatic patch16(int unsigned at, logic [15:0] v);
        hello[at]     = v[15:8];
        hello[at + 1] = v[7:0];
    endtask

    task automatic add_other_ext();
        logic [15:0] kind;
        int unsigned n;
        kind = 16'($urandom_range(1, 16'hFFFF));
        n    = $urandom_range(0, 6);
        put(kind[15:8], 1'b1);
        put(kind[7:0], 1'b1);
        put(8'h00, 1'b1);
        put(8'(n), 1'b1);
        repeat (n) put(rnd8(), 1'b0);
    endtask

    task automatic add_name_entry(logic [7:0] kind, logic [15:0] n);
        put(kind, 1'b1);
        put(n[15:8], 1'b1);
        put(n[7:0], 1'b1);
        repeat (n) put(rnd8(), 1'b0);
    endtask

    task automatic add_sni_ext();
        int unsigned ext_at, list_at, tail;
        logic [15:0] n;
        put(EXT_SERVER_NAME[15:8], 1'b1);
        put(EXT_SERVER_NAME[7:0], 1'b1);
        ext_at = hello.size();
        put(8'h00, 1'b1);
        put(8'h00, 1'b1);
        list_at = hello.size();
        put(8'h00, 1'b1);
        put(8'h00, 1'b1);
        tail = $urandom_range(0, 1);
        repeat ($urandom_range(0, 1))
            add_name_entry(8'($urandom_range(1, 255)), 16'($urandom_range(0, 4)));
        if ($urandom_range(0, 7) != 0) begin
            n = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
            add_name_entry(NAME_HOST, n);
            // an empty name needs something after it to be a legal last entry
            if (n == 0) tail = 1;
        end
        repeat (tail) add_name_entry(rnd8(), 16'($urandom_range(1, 4)));
        patch16(list_at, 16'(hello.size() - list_at - 2));
        patch16(ext_at, 16'(hello.size() - ext_at - 2));
    endtask

    task automatic build_hello();
        int unsigned n, ext_at;
        hello.delete();
        field_at.delete();
        put(CT_HANDSHAKE, 1'b1);
        put(TLS_MAJOR, 1'b1);
        put(rnd8(), 1'b1);
        put(8'h00, 1'b1);
        put(8'h00, 1'b1);
        put(HS_CLIENT_HELLO, 1'b1);
        repeat (3) put(rnd8(), 1'b0);
        put(TLS_MAJOR, 1'b0);
        repeat (33) put(rnd8(), 1'b0);
        n = $urandom_range(0, 32);
        put(8'(n), 1'b1);
        repeat (n) put(rnd8(), 1'b0);
        n = 2 * $urandom_range(0, 4);
        put(8'h00, 1'b1);
        put(8'(n), 1'b1);
        repeat (n) put(rnd8(), 1'b0);
        n = $urandom_range(0, 3);
        put(8'(n), 1'b1);
        repeat (n) put(rnd8(), 1'b0);
        // now and then the hello ends right after the compression methods
        if ($urandom_range(0, 9) != 0) begin
            ext_at = hello.size();
            put(8'h00, 1'b1);
            put(8'h00, 1'b1);
            repeat ($urandom_range(0, 2)) add_other_ext();
            if ($urandom_range(0, 7) != 0) add_sni_ext();
            repeat ($urandom_range(0, 1)) add_other_ext();
            patch16(ext_at, 16'(hello.size() - ext_at - 2));
        end
        patch16(3, 16'(hello.size() - HDR_BYTES));
    endtask

    task automatic spoil_hello();
        int unsigned at;
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 9) < 7) at = field_at[$urandom_range(0, field_at.size() - 1)];
            else at = $urandom_range(0, hello.size() - 1);
            case ($urandom_range(0, 2))
                0: hello[at] = hello[at] + 8'd1;
                1: hello[at] = hello[at] - 8'd1;
                default: hello[at] = rnd8();
            endcase
        end
    endtask

    task automatic queue_payload();
        t_in_req rq;
        foreach (hello[k]) begin
            rq.data_byte   = hello[k];
            rq.end_of_data = (k == hello.size() - 1);
            payload_bytes.push_back(rq);
        end
        bytes_queued += hello.size();
    endtask

    task automatic random_payload();
        int unsigned pick, n;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            build_hello();
            if (pick >= 55 && pick < 70) begin
                n = $urandom_range(1, hello.size());
                while (hello.size() > n) hello.delete(hello.size() - 1);
            end else if (pick >= 70) spoil_hello();
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) hello.push_back(rnd8());
        end else begin
            hello.delete();
            n = (pick < 93) ? $urandom_range(3, 8) : $urandom_range(1, 12);
            repeat (n) hello.push_back(rnd8());
            if (pick < 93) begin
                case ($urandom_range(0, 2))
                    0: hello[0] = CT_HANDSHAKE;
                    1: begin
                        hello[0] = hello[0] | 8'h80;
                        hello[2] = SSL2_HELLO;
                    end
                    default: ;
                endcase
            end
        end
        queue_payload();
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned hold_pct);
        int unsigned start;
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = hold_pct;
        start = bytes_queued;
        while (bytes_queued - start < BYTES_PER_PHASE) random_payload();
        do @(negedge i_clk); while (payload_bytes.size() != 0 || i_valid);
    endtask

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    // ---------------- clock, driver, monitor ----------------

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (payload_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_req   <= payload_bytes.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
            if (i_valid && o_ready) begin
                hello_parse_byte(i_req);
                bytes_taken++;
            end
            if (o_valid && i_ready) begin
                if (o_req.result_kind == KIND_STATUS) status_seen[o_req.parse_status]++;
                else name_bytes_seen++;
                if (sni_results_due.size() == 0) begin
                    $error("unexpected request: kind %0d byte 0x%0h status %0d length %0d",
                           o_req.result_kind, o_req.name_byte, o_req.parse_status,
                           o_req.name_length);
                    mismatches++;
                end else begin
                    due = sni_results_due.pop_front();
                    compare_field("result_kind", due.result_kind, o_req.result_kind);
                    compare_field("name_byte", due.name_byte, o_req.name_byte);
                    compare_field("parse_status", due.parse_status, o_req.parse_status);
                    compare_field("name_length", due.name_length, o_req.name_length);
                    compare_field("final_result", due.final_result, o_req.final_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[tls_sni_hostname_extractor] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        parser_clear();
        // short payload, SSLv2 hello, wrong content type, old major version,
        // empty record
        hello = '{8'hFF};
        queue_payload();
        hello = '{8'h80, 8'h00, SSL2_HELLO, 8'h00, 8'h00};
        queue_payload();
        hello = '{8'h17, TLS_MAJOR, 8'h01, 8'h00, 8'h10};
        queue_payload();
        hello = '{CT_HANDSHAKE, 8'h02, 8'hFF, 8'hFF, 8'hFF};
        queue_payload();
        hello = '{CT_HANDSHAKE, TLS_MAJOR, 8'h03, 8'h00, 8'h00};
        queue_payload();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(6, 6);

        do @(negedge i_clk); while (sni_results_due.size() != 0);
        repeat (16) @(negedge i_clk);

        $display("Sent %0d payload bytes; checked %0d host name bytes.",
                 bytes_taken, name_bytes_seen);
        $display("Payload outcomes: found %0d, incomplete %0d, no name %0d, invalid %0d.",
                 status_seen[ST_FOUND], status_seen[ST_INCOMPLETE],
                 status_seen[ST_NO_SNI], status_seen[ST_INVALID]);
        if (mismatches == 0) begin
            $display("[tls_sni_hostname_extractor] OK");
        end else begin
            $display("[tls_sni_hostname_extractor] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tse_pkg.sv
hw/rtl/tse_parser.sv
hw/rtl/tse_out_queue.sv
hw/rtl/tls_sni_hostname_extractor.sv
hw/rtl/tse_checker.sv
bench/tb_top.sv
